@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Every check samples on the rising edge of clk_i and is held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds.
`define KBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never occurs.
`define KBS_NEVER(lbl, cond, msg) \
  `KBS_ASSERT(lbl, !(cond), msg)

`endif

@@ src/kbs_pkg.sv @@
`default_nettype none

package kbs_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  localparam logic REG_STATUS = 1'b0;
  localparam logic REG_DATA   = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_CHAR = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  key_code;
    logic        reg_select;
    logic [15:0] write_data;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] result_value;
    logic        is_last;
  } out_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] key;
  } stack_req_t;

  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] lo;
    logic       any;
    logic       many;
  } stack_rsp_t;

endpackage

`default_nettype wire

@@ src/kbs_key_stack.sv @@
`default_nettype none

module kbs_key_stack
  import kbs_pkg::*;
#(
  parameter int unsigned KEY_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stack_req_t req_i,
  output stack_rsp_t rsp_o
);

  `include "assert_macros.svh"

  localparam int unsigned AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned CW = $clog2(KEY_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(KEY_DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);
  localparam logic [CW-1:0] TwoC   = CW'(2);

  logic [7:0]    mem [KEY_DEPTH];
  logic [7:0]    hi_q, lo_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] count_m1, count_m2;
  logic          full;
  logic          many;

  assign full     = (count_q == DepthC);
  assign many     = (count_q >= TwoC);
  assign count_m1 = count_q - OneC;
  assign count_m2 = count_q - TwoC;

  always_comb begin
    count_d = count_q;
    if (req_i.push && !full) begin
      count_d = count_q + OneC;
    end else if (req_i.pop) begin
      count_d = many ? count_m2 : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Push writes at the slot just above the top; drop when full.
  always_ff @(posedge clk_i) begin
    if (req_i.push && !full) begin
      mem[count_q[AW-1:0]] <= req_i.key;
    end
  end

  // Top two entries, registered; only used when the count says they exist.
  always_ff @(posedge clk_i) begin
    if (req_i.pop) begin
      hi_q <= mem[count_m1[AW-1:0]];
      lo_q <= mem[count_m2[AW-1:0]];
    end
  end

  assign rsp_o.hi   = hi_q;
  assign rsp_o.lo   = lo_q;
  assign rsp_o.any  = (count_q != '0);
  assign rsp_o.many = many;

  `KBS_NEVER(a_count_range, count_q > DepthC, "key count beyond store depth")
  `KBS_ASSERT(a_pop_two, req_i.pop && !req_i.push && many |=> count_q == $past(count_m2),
              "double pop did not remove two keys")
  `KBS_ASSERT(a_full_drop, req_i.push && full |=> count_q == DepthC,
              "push into full store changed the count")

endmodule

`default_nettype wire

@@ src/keyboard_stack_console_port_unit.sv @@
// Keystroke stack and console port.
// Input channel in_valid_i / in_ready_o carries one in_t transaction: push a
// keystroke, read register 0 (key waiting) or 1 (pop keys), or write a word
// whose two bytes go to the console, high byte first, zero bytes skipped.
// Output channel out_valid_o / out_ready_i carries out_t results; is_last marks
// the final result of a transaction. Pushes, unused commands and writes of
// two zero bytes give no result.
// A result passes the item register, then the output register, before it is
// offered. Reads and single-character writes are taken one per cycle while
// the receiver does not stall; a write with two nonzero bytes holds the item
// register until both characters have gone, as the output register carries
// one result per cycle. Key store state changes at the edge the transaction is
// accepted, so back-to-back pushes and pops see each other in order.
// Reset empties the key store (count cleared) and drops both registers.
// When the receiver stalls, the output register holds its result, the item
// register fills behind it and in_ready_o falls until the output drains.
`default_nettype none

module keyboard_stack_console_port_unit
  import kbs_pkg::*;
#(
  parameter int unsigned KEY_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  `include "assert_macros.svh"

  stack_req_t req;
  stack_rsp_t rsp;

  kbs_key_stack #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_stack (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  logic       accept;
  logic       has_result;
  logic       is_push, is_read, is_write;

  logic       a_valid_q, a_valid_d;
  logic       a_phase_q, a_phase_d;
  logic       a_write_q, a_sel_q, a_any_q, a_many_q;
  logic [7:0] a_hi_q, a_lo_q;
  logic       a_emit, a_last;
  out_t       a_result;

  logic       out_valid_q, out_valid_d;
  out_t       out_q;
  logic       out_free;
  logic [7:0] chr;

  always_comb begin
    is_push  = 1'b0;
    is_read  = 1'b0;
    is_write = 1'b0;
    unique case (in_data_i.command)
      CMD_PUSH:  is_push  = 1'b1;
      CMD_READ:  is_read  = 1'b1;
      CMD_WRITE: is_write = 1'b1;
      default:   ;
    endcase
  end

  assign has_result = is_read || (is_write && (in_data_i.write_data != 16'h0000));
  assign accept     = in_valid_i && in_ready_o;

  assign req.push = accept && is_push;
  assign req.pop  = accept && is_read && (in_data_i.reg_select == REG_DATA);
  assign req.key  = in_data_i.key_code;

  assign out_free = !out_valid_q || out_ready_i;
  assign a_emit   = a_valid_q && out_free;

  // Build the result the item register offers this cycle.
  always_comb begin
    chr = (!a_phase_q && (a_hi_q != 8'h00)) ? a_hi_q : a_lo_q;
    if (a_write_q) begin
      a_last                = a_phase_q || (a_hi_q == 8'h00) || (a_lo_q == 8'h00);
      a_result.result_kind  = KIND_CHAR;
      a_result.result_value = {8'h00, chr};
    end else begin
      a_last               = 1'b1;
      a_result.result_kind = KIND_READ;
      if (a_sel_q == REG_DATA) begin
        if (!a_any_q) begin
          a_result.result_value = 16'h0000;
        end else if (!a_many_q) begin
          a_result.result_value = {rsp.hi, 8'h00};
        end else begin
          a_result.result_value = {rsp.hi, rsp.lo};
        end
      end else begin
        a_result.result_value = {15'h0000, a_any_q};
      end
    end
    a_result.is_last = a_last;
  end

  assign in_ready_o = !a_valid_q || (a_emit && a_last);

  always_comb begin
    a_valid_d = a_valid_q;
    a_phase_d = a_phase_q;
    if (in_ready_o) begin
      a_valid_d = accept && has_result;
      a_phase_d = 1'b0;
    end else if (a_emit) begin
      // First of two characters gone: advance to the low byte.
      a_phase_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (a_emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      a_phase_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      a_phase_q   <= a_phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_write_q <= is_write;
      a_sel_q   <= in_data_i.reg_select;
      a_any_q   <= rsp.any;
      a_many_q  <= rsp.many;
      a_hi_q    <= in_data_i.write_data[15:8];
      a_lo_q    <= in_data_i.write_data[7:0];
    end
    if (a_emit) begin
      out_q <= a_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `KBS_ASSERT(a_phase_write, a_phase_q |-> a_valid_q && a_write_q,
              "second character phase outside a write")
  `KBS_ASSERT(a_early_char, out_valid_q && !out_q.is_last |-> out_q.result_kind == KIND_CHAR,
              "non-final result that is not a console character")
  `KBS_ASSERT(a_second_char, a_emit && !a_last |=> a_valid_q && a_phase_q,
              "write lost its second character")

endmodule

`default_nettype wire

@@ verif/kbs_port_checker.sv @@
`timescale 1ns / 1ps

module kbs_port_checker
  import kbs_pkg::*;
#(
  parameter int unsigned KEY_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  logic [7:0]  key_stack [KEY_DEPTH];
  int unsigned key_total;
  out_t        results_due [$];
  int          mismatches = 0;

  task automatic report(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_result(input logic kind, input logic [15:0] value, input logic last);
    out_t r;
    r.result_kind  = kind;
    r.result_value = value;
    r.is_last      = last;
    results_due.push_back(r);
  endtask

  // Advance the key stack and queue whatever the transaction should produce.
  task automatic apply_transaction(input in_t t);
    logic [15:0] word;
    logic [7:0]  hi;
    logic [7:0]  lo;
    case (t.command)
      CMD_PUSH: begin
        // drop the key when the stack is full
        if (key_total < KEY_DEPTH) begin
          key_stack[AW'(key_total)] = t.key_code;
          key_total++;
        end
      end
      CMD_READ: begin
        if (t.reg_select == REG_DATA) begin
          if (key_total == 0) begin
            word = 16'h0000;
          end else if (key_total == 1) begin
            word      = {key_stack[0], 8'h00};
            key_total = 0;
          end else begin
            word      = {key_stack[AW'(key_total - 1)], key_stack[AW'(key_total - 2)]};
            key_total = key_total - 2;
          end
        end else begin
          word = (key_total != 0) ? 16'h0001 : 16'h0000;
        end
        queue_result(KIND_READ, word, 1'b1);
      end
      CMD_WRITE: begin
        hi = t.write_data[15:8];
        lo = t.write_data[7:0];
        if (hi != 8'h00) queue_result(KIND_CHAR, {8'h00, hi}, lo == 8'h00);
        if (lo != 8'h00) queue_result(KIND_CHAR, {8'h00, lo}, 1'b1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      key_total = 0;
      results_due.delete();
      pending_o <= 0;
    end else begin
      // results leave after their transaction, so check before predicting
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          report($sformatf("unexpected result kind %0b value %h last %0b",
                           out_data_i.result_kind, out_data_i.result_value,
                           out_data_i.is_last));
        end else begin
          want = results_due.pop_front();
          if (out_data_i.result_kind !== want.result_kind)
            report($sformatf("result_kind got %0b, want %0b",
                             out_data_i.result_kind, want.result_kind));
          if (out_data_i.result_value !== want.result_value)
            report($sformatf("result_value got %h, want %h",
                             out_data_i.result_value, want.result_value));
          if (out_data_i.is_last !== want.is_last)
            report($sformatf("is_last got %0b, want %0b",
                             out_data_i.is_last, want.is_last));
        end
      end
      if (in_valid_i && in_ready_i) apply_transaction(in_data_i);
      pending_o <= results_due.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

@@ verif/tb_keyboard_stack_console_port_unit.sv @@
`timescale 1ns / 1ps

module tb_keyboard_stack_console_port_unit;
  import kbs_pkg::*;

  localparam int unsigned KEY_DEPTH  = 16;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  int fail_count;
  int results_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always #1 clk_i = ~clk_i;

  keyboard_stack_console_port_unit #(
    .KEY_DEPTH(KEY_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  kbs_port_checker #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (results_pending)
  );

  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Fill every field at random so unused ones toggle too.
  function automatic in_t noisy(input logic [1:0] cmd);
    in_t t;
    t.command    = cmd;
    t.key_code   = 8'($urandom);
    t.reg_select = 1'($urandom);
    t.write_data = 16'($urandom);
    return t;
  endfunction

  // Hold valid until the transaction is taken, then idle at random.
  task automatic send(input in_t t);
    in_data  <= t;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_push(input logic [7:0] key);
    in_t t;
    t          = noisy(CMD_PUSH);
    t.key_code = key;
    send(t);
  endtask

  task automatic send_read(input logic sel);
    in_t t;
    t            = noisy(CMD_READ);
    t.reg_select = sel;
    send(t);
  endtask

  task automatic send_write(input logic [15:0] word);
    in_t t;
    t            = noisy(CMD_WRITE);
    t.write_data = word;
    send(t);
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    int n;
    int r;
    int burst;
    logic [7:0] hi;
    logic [7:0] lo;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    n = 0;
    // open with a run long enough to overflow the stack
    repeat (KEY_DEPTH + 3) send_push(8'($urandom));
    n += KEY_DEPTH + 3;
    while (n < count) begin
      r = $urandom_range(99);
      if (r < 6) begin
        burst = $urandom_range(10, 20);
        repeat (burst) send_push(8'($urandom));
        n += burst;
      end else if (r < 45) begin
        send_push(8'($urandom));
        n++;
      end else if (r < 80) begin
        send_read(($urandom_range(99) < 75) ? REG_DATA : REG_STATUS);
        n++;
      end else if (r < 96) begin
        hi = ($urandom_range(99) < 20) ? 8'h00 : 8'($urandom);
        lo = ($urandom_range(99) < 20) ? 8'h00 : 8'($urandom);
        send_write({hi, lo});
        n++;
      end else begin
        send(noisy(CMD_UNUSED));
        n++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stack: status and data both read zero
    send_read(REG_STATUS);
    send_read(REG_DATA);
    send_push(8'h00);
    send_read(REG_STATUS);
    send_read(REG_DATA);
    // console writes: no byte, high only, low only, both
    send_write(16'h0000);
    send_write(16'hFF00);
    send_write(16'h00FF);
    send_write(16'hFFFF);
    send_write(16'h8001);
    send(noisy(CMD_UNUSED));
    // pop two, then the single leftover
    send_push(8'hFF);
    send_push(8'h01);
    send_push(8'h80);
    send_read(REG_DATA);
    send_read(REG_STATUS);
    send_read(REG_DATA);
    send_read(REG_STATUS);
    drain();

    run_phase(0, 0, 230);
    run_phase(75, 0, 230);
    run_phase(0, 75, 230);
    run_phase(32, 32, 230);

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
